>>> hw/rtl/dtd_pkg.sv
// Shared types, character codes and binary64 helpers for the decimal text converter.
// No dependencies; the parser, queue, divider, sequencer and top level import this package.
package dtd_pkg;

    // Character codes recognised by the parser.
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_E     = 8'h65;

    // Binary64 constants.
    localparam logic [63:0] DBL_ZERO = 64'h0000_0000_0000_0000;
    localparam logic [63:0] DBL_ONE  = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] DBL_TEN  = 64'h4024_0000_0000_0000;
    localparam logic [63:0] DBL_QNAN = 64'h7FF8_0000_0000_0000;
    localparam logic [62:0] MAG_INF  = 63'h7FF0_0000_0000_0000;
    localparam logic [10:0] EXP_ONES = 11'h7FF;

    // Working significand: leading one at bit 55, three bits below the 53-bit mantissa.
    localparam int SIG_W    = 56;
    localparam int QUO_BITS = 56;

    // Queue between parser and arithmetic sequencer.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [3:0] {
        PH_WS, PH_SIGN, PH_INT, PH_DOT, PH_FRAC, PH_E, PH_ESIGN, PH_EXP, PH_DONE
    } parse_phase_t;

    typedef enum logic [2:0] {
        B_IDLE, B_DISPATCH, B_MUL, B_ADD, B_ROUND, B_DIV_WAIT, B_OUT
    } back_state_t;

    typedef enum logic [2:0] {
        J_NONE, J_MUL_M, J_ADD_M, J_MUL_P, J_EXP_MUL, J_EXP_DIV, J_FINAL
    } job_t;

    typedef enum logic [2:0] {
        D_IDLE, D_NORM, D_ITER, D_ROUND, D_DONE
    } div_state_t;

    // One queue entry: the arithmetic a single character asks for.
    typedef struct packed {
        logic        has_digit;
        logic        is_frac;
        logic [3:0]  digit;
        logic        fin;
        logic        neg;
        logic        exp_neg;
        logic [10:0] exp_cnt;
    } q_entry_t;

    // Status of the arithmetic sequencer seen by the top level.
    typedef struct packed {
        logic delivering;
        logic final_div;
    } back_stat_t;

    // Exact binary64 encoding of a decimal digit.
    function automatic logic [63:0] digit_double(input logic [3:0] d);
        logic [63:0] r;
        case (d)
            4'd1:    r = 64'h3FF0_0000_0000_0000;
            4'd2:    r = 64'h4000_0000_0000_0000;
            4'd3:    r = 64'h4008_0000_0000_0000;
            4'd4:    r = 64'h4010_0000_0000_0000;
            4'd5:    r = 64'h4014_0000_0000_0000;
            4'd6:    r = 64'h4018_0000_0000_0000;
            4'd7:    r = 64'h401C_0000_0000_0000;
            4'd8:    r = 64'h4020_0000_0000_0000;
            4'd9:    r = 64'h4022_0000_0000_0000;
            default: r = DBL_ZERO;
        endcase
        return r;
    endfunction

    // Rounds value = s / 2^55 * 2^e (s[55] set) to nearest even and packs the
    // magnitude, handling gradual underflow and overflow to infinity.
    function automatic logic [62:0] round_pack(input logic signed [12:0] e,
                                               input logic [SIG_W-1:0] s,
                                               input logic st);
        logic signed [12:0] shv;
        logic [SIG_W-1:0]   s2;
        logic [SIG_W-1:0]   mask;
        logic               st2;
        logic [10:0]        field;
        logic [62:0]        pre;
        logic               up;
        shv  = 13'sd0;
        mask = '0;
        if (e < -13'sd1022) begin
            shv = -13'sd1022 - e;
        end
        if (shv > 13'sd55) begin
            s2  = '0;
            st2 = st | (|s);
        end else begin
            mask = (56'd1 << shv[5:0]) - 56'd1;
            s2   = s >> shv[5:0];
            st2  = st | (|(s & mask));
        end
        field = (e < -13'sd1022) ? 11'd0 : 11'(e + 13'sd1023);
        pre   = {field, s2[54:3]};
        up    = s2[2] & (s2[3] | s2[1] | s2[0] | st2);
        if (e > 13'sd1023) begin
            return MAG_INF;
        end
        return pre + 63'(up);
    endfunction

endpackage

>>> hw/rtl/dtd_in_if.sv
// Input channel of the converter: one character per transfer.
// No dependencies.
interface dtd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       end_of_text;

    modport source (output valid, output text_char, output end_of_text, input ready);
    modport sink   (input valid, input text_char, input end_of_text, output ready);
endinterface

>>> hw/rtl/dtd_out_if.sv
// Output channel of the converter: one binary64 value per transfer.
// No dependencies.
interface dtd_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] value_bits;

    modport source (output valid, output value_bits, input ready);
    modport sink   (input valid, input value_bits, output ready);
endinterface

>>> hw/rtl/dtd_front.sv
// Character parser: walks the number grammar and queues the arithmetic each character needs.
// Depends on dtd_pkg and dtd_in_if.
module dtd_front
    import dtd_pkg::*;
#(
    parameter int EXPONENT_LIMIT = 1023
)
(
    input  logic     clk,
    input  logic     rst_n,
    dtd_in_if.sink   chars,
    input  logic     q_full,
    output logic     q_push,
    output q_entry_t q_data
);

    parse_phase_t phase_reg, phase_next;
    logic         neg_reg, neg_next;
    logic         eneg_reg, eneg_next;
    logic [10:0]  ecnt_reg, ecnt_next;
    logic         dig_int, dig_frac, taken;
    logic [7:0]   c;
    logic         is_digit;
    logic [14:0]  e_wide;
    logic         accept;

    assign c        = chars.text_char;
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign e_wide   = 15'(ecnt_reg) * 15'd10 + 15'(c[3:0]);

    // The grammar falls through from phase to phase until one consumes the character.
    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        eneg_next  = eneg_reg;
        ecnt_next  = ecnt_reg;
        dig_int    = 1'b0;
        dig_frac   = 1'b0;
        taken      = 1'b0;
        if (phase_next == PH_WS) begin
            if (c inside {CH_SPACE, [CH_TAB:CH_CR]}) taken = 1'b1;
            else phase_next = PH_SIGN;
        end
        if (!taken && phase_next == PH_SIGN) begin
            phase_next = PH_INT;
            if (c == CH_MINUS || c == CH_PLUS) begin
                neg_next = (c == CH_MINUS);
                taken    = 1'b1;
            end
        end
        if (!taken && phase_next == PH_INT) begin
            if (is_digit) begin
                dig_int = 1'b1;
                taken   = 1'b1;
            end else begin
                phase_next = PH_DOT;
            end
        end
        if (!taken && phase_next == PH_DOT) begin
            phase_next = PH_FRAC;
            taken      = (c == CH_DOT);
        end
        if (!taken && phase_next == PH_FRAC) begin
            if (is_digit) begin
                dig_frac = 1'b1;
                taken    = 1'b1;
            end else begin
                phase_next = PH_E;
            end
        end
        if (!taken && phase_next == PH_E) begin
            phase_next = PH_ESIGN;
            taken      = (c == CH_E);
        end
        if (!taken && phase_next == PH_ESIGN) begin
            phase_next = PH_EXP;
            if (c == CH_MINUS || c == CH_PLUS) begin
                eneg_next = (c == CH_MINUS);
                taken     = 1'b1;
            end
        end
        if (!taken && phase_next == PH_EXP) begin
            if (is_digit) begin
                ecnt_next = (e_wide > 15'(EXPONENT_LIMIT)) ? 11'(EXPONENT_LIMIT)
                                                           : 11'(e_wide);
            end else begin
                phase_next = PH_DONE;
            end
            taken = 1'b1;
        end
        if (!taken) begin
            phase_next = PH_DONE;
        end
    end

    assign chars.ready = !q_full;
    assign accept      = chars.valid && chars.ready;
    assign q_push      = accept && (dig_int || dig_frac || chars.end_of_text);

    always_comb
    begin
        q_data.has_digit = dig_int || dig_frac;
        q_data.is_frac   = dig_frac;
        q_data.digit     = c[3:0];
        q_data.fin       = chars.end_of_text;
        q_data.neg       = neg_next;
        q_data.exp_neg   = eneg_next;
        q_data.exp_cnt   = ecnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_WS;
            neg_reg   <= 1'b0;
            eneg_reg  <= 1'b0;
            ecnt_reg  <= '0;
        end else if (accept) begin
            if (chars.end_of_text) begin
                phase_reg <= PH_WS;
                neg_reg   <= 1'b0;
                eneg_reg  <= 1'b0;
                ecnt_reg  <= '0;
            end else begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                eneg_reg  <= eneg_next;
                ecnt_reg  <= ecnt_next;
            end
        end
    end

endmodule

>>> hw/rtl/dtd_fifo.sv
// Short queue of parsed work entries between the parser and the arithmetic sequencer.
// Depends on dtd_pkg.
module dtd_fifo
    import dtd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  q_entry_t push_data,
    output logic     full,
    input  logic     pop,
    output q_entry_t pop_data,
    output logic     empty
);

    q_entry_t            mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

>>> hw/rtl/dtd_div.sv
// Iterative binary64 divider for non-negative operands, one quotient bit per cycle.
// Depends on dtd_pkg.
module dtd_div
    import dtd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    input  logic        neg,
    output logic        done,
    output logic [63:0] q
);

    div_state_t         state_reg, state_next;
    logic [52:0]        ma_reg, mb_reg;
    logic signed [12:0] ea_reg, eb_reg, e_reg;
    logic [53:0]        rem_reg;
    logic [SIG_W-1:0]   quo_reg;
    logic [5:0]         cnt_reg;
    logic               neg_reg;
    logic [63:0]        res_reg;

    logic               a_zero, b_zero, a_inf, b_inf, special;
    logic [53:0]        diff;
    logic               qbit;

    assign a_zero  = (a[62:0] == '0);
    assign b_zero  = (b[62:0] == '0);
    assign a_inf   = (a[62:52] == EXP_ONES);
    assign b_inf   = (b[62:52] == EXP_ONES);
    assign special = a_zero || b_zero || a_inf || b_inf;
    assign diff    = rem_reg - {1'b0, mb_reg};
    assign qbit    = (rem_reg >= {1'b0, mb_reg});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            D_IDLE:  if (start) state_next = special ? D_DONE : D_NORM;
            D_NORM:  if (ma_reg[52] && mb_reg[52]) state_next = D_ITER;
            D_ITER:  if (cnt_reg == 6'(QUO_BITS - 1)) state_next = D_ROUND;
            D_ROUND: state_next = D_DONE;
            D_DONE:  state_next = D_IDLE;
            default: state_next = D_IDLE;
        endcase
    end

    always_comb
    begin
        done = (state_reg == D_DONE);
        q    = res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= D_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // The result stays in res_reg until the next start, so a held output can still read it.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            D_IDLE:
            begin
                if (start) begin
                    neg_reg <= neg;
                    ma_reg  <= {a[62:52] != 11'd0, a[51:0]};
                    mb_reg  <= {b[62:52] != 11'd0, b[51:0]};
                    ea_reg  <= (a[62:52] == 11'd0) ? -13'sd1022
                                                   : $signed({2'b00, a[62:52]}) - 13'sd1023;
                    eb_reg  <= (b[62:52] == 11'd0) ? -13'sd1022
                                                   : $signed({2'b00, b[62:52]}) - 13'sd1023;
                    // Zero over zero and infinity over infinity give the canonical NaN.
                    if ((a_zero && b_zero) || (a_inf && b_inf)) res_reg <= DBL_QNAN;
                    else if (a_inf || b_zero)                   res_reg <= {neg, MAG_INF};
                    else                                        res_reg <= {neg, 63'd0};
                end
            end
            D_NORM:
            begin
                if (ma_reg[52] && mb_reg[52]) begin
                    if (ma_reg < mb_reg) begin
                        rem_reg <= {ma_reg, 1'b0};
                        e_reg   <= ea_reg - eb_reg - 13'sd1;
                    end else begin
                        rem_reg <= {1'b0, ma_reg};
                        e_reg   <= ea_reg - eb_reg;
                    end
                    cnt_reg <= '0;
                end else begin
                    if (!ma_reg[52]) begin
                        ma_reg <= {ma_reg[51:0], 1'b0};
                        ea_reg <= ea_reg - 13'sd1;
                    end
                    if (!mb_reg[52]) begin
                        mb_reg <= {mb_reg[51:0], 1'b0};
                        eb_reg <= eb_reg - 13'sd1;
                    end
                end
            end
            D_ITER:
            begin
                rem_reg <= qbit ? {diff[52:0], 1'b0} : {rem_reg[52:0], 1'b0};
                quo_reg <= {quo_reg[SIG_W-2:0], qbit};
                cnt_reg <= cnt_reg + 6'd1;
            end
            D_ROUND:
            begin
                res_reg <= {neg_reg, round_pack(e_reg, quo_reg, rem_reg != '0)};
            end
            default:
            begin
            end
        endcase
    end

endmodule

>>> hw/rtl/dtd_back.sv
// Arithmetic sequencer: runs the queued digit updates, the exponent loop and the final division.
// Depends on dtd_pkg, dtd_out_if and dtd_div.
module dtd_back
    import dtd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  q_entry_t   q_data,
    output logic       q_pop,
    dtd_out_if.source  values,
    output back_stat_t stat
);

    back_state_t        state_reg, state_next;
    job_t               job;
    q_entry_t           ent_reg;
    logic [63:0]        m_reg, p_reg;
    logic               mul_m_reg, add_m_reg, mul_p_reg, fin_div_reg, final_run_reg;
    logic [10:0]        cnt_reg;
    logic               tgt_p_reg;
    logic signed [12:0] pre_e_reg;
    logic [SIG_W-1:0]   pre_s_reg;
    logic               pre_st_reg, pre_sp_reg;
    logic [63:0]        pre_bits_reg;
    logic               out_valid_reg;
    logic [63:0]        out_bits_reg;

    logic               div_start, div_done, div_neg, out_load;
    logic [63:0]        div_a, div_b, div_q;

    // Multiply by ten, add a digit: pre-rounding results.
    logic [63:0]        mx;
    logic signed [12:0] mx_e0, ax_e0, ash;
    logic [56:0]        prod, sum;
    logic [SIG_W-1:0]   dsig, dal, dmask;
    logic               dlost;
    logic               mul_sp, add_sp;
    logic [63:0]        mul_bits, add_bits;
    logic signed [12:0] mul_e, add_e;
    logic [SIG_W-1:0]   mul_s, add_s;
    logic               mul_st, add_st;
    logic [63:0]        rounded;

    dtd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .a     (div_a),
        .b     (div_b),
        .neg   (div_neg),
        .done  (div_done),
        .q     (div_q)
    );

    always_comb
    begin
        mx       = tgt_p_reg ? p_reg : m_reg;
        mx_e0    = $signed({2'b00, mx[62:52]}) - 13'sd1023;
        prod     = ({4'b0, 1'b1, mx[51:0]} << 3) + ({4'b0, 1'b1, mx[51:0]} << 1);
        mul_sp   = (mx[62:52] == 11'd0) || (mx[62:52] == EXP_ONES);
        mul_bits = (mx[62:52] == 11'd0) ? DBL_ZERO : {1'b0, MAG_INF};
        if (prod[56]) begin
            mul_s  = prod[56:1];
            mul_st = prod[0];
            mul_e  = mx_e0 + 13'sd4;
        end else begin
            mul_s  = prod[55:0];
            mul_st = 1'b0;
            mul_e  = mx_e0 + 13'sd3;
        end
    end

    // The addend is never larger than the running value once that is non-zero.
    always_comb
    begin
        ax_e0 = $signed({2'b00, m_reg[62:52]}) - 13'sd1023;
        ash   = ax_e0 - 13'sd3;
        dsig  = {ent_reg.digit, 52'd0};
        dmask = '0;
        if (ash > 13'sd55) begin
            dal   = '0;
            dlost = 1'b1;
        end else begin
            dmask = (56'd1 << ash[5:0]) - 56'd1;
            dal   = dsig >> ash[5:0];
            dlost = |(dsig & dmask);
        end
        sum      = {1'b0, 1'b1, m_reg[51:0], 3'b000} + {1'b0, dal};
        add_sp   = (m_reg[62:52] == EXP_ONES) || (ent_reg.digit == 4'd0) ||
                   (m_reg[62:52] == 11'd0);
        add_bits = (m_reg[62:52] == EXP_ONES) ? {1'b0, MAG_INF} :
                   (ent_reg.digit == 4'd0)    ? m_reg : digit_double(ent_reg.digit);
        if (sum[56]) begin
            add_s  = sum[56:1];
            add_st = dlost | sum[0];
            add_e  = ax_e0 + 13'sd1;
        end else begin
            add_s  = sum[55:0];
            add_st = dlost;
            add_e  = ax_e0;
        end
    end

    assign rounded = pre_sp_reg ? pre_bits_reg
                                : {1'b0, round_pack(pre_e_reg, pre_s_reg, pre_st_reg)};

    // Work selection: digit update first, then the exponent loop, then the final division.
    always_comb
    begin
        if (mul_m_reg)                          job = J_MUL_M;
        else if (add_m_reg)                     job = J_ADD_M;
        else if (mul_p_reg)                     job = J_MUL_P;
        else if (ent_reg.fin && cnt_reg != '0)  job = ent_reg.exp_neg ? J_EXP_MUL : J_EXP_DIV;
        else if (ent_reg.fin && fin_div_reg)    job = J_FINAL;
        else                                    job = J_NONE;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:     if (!q_empty) state_next = B_DISPATCH;
            B_DISPATCH:
            begin
                case (job)
                    J_MUL_M, J_MUL_P, J_EXP_MUL: state_next = B_MUL;
                    J_ADD_M:                     state_next = B_ADD;
                    J_EXP_DIV, J_FINAL:          state_next = B_DIV_WAIT;
                    default:                     state_next = B_IDLE;
                endcase
            end
            B_MUL, B_ADD: state_next = B_ROUND;
            B_ROUND:      state_next = B_DISPATCH;
            B_DIV_WAIT:   if (div_done) state_next = final_run_reg ? B_OUT : B_DISPATCH;
            B_OUT:        if (!out_valid_reg || values.ready) state_next = B_IDLE;
            default:      state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop           = (state_reg == B_IDLE) && !q_empty;
        div_start       = (state_reg == B_DISPATCH) && (job == J_EXP_DIV || job == J_FINAL);
        div_a           = (job == J_FINAL) ? m_reg : p_reg;
        div_b           = (job == J_FINAL) ? p_reg : DBL_TEN;
        div_neg         = (job == J_FINAL) && ent_reg.neg;
        out_load        = (state_reg == B_OUT) && (!out_valid_reg || values.ready);
        stat.delivering = (state_reg == B_OUT);
        stat.final_div  = (state_reg == B_DIV_WAIT) && final_run_reg;
        values.valid      = out_valid_reg;
        values.value_bits = out_bits_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= B_IDLE;
            m_reg         <= DBL_ZERO;
            p_reg         <= DBL_ONE;
            mul_m_reg     <= 1'b0;
            add_m_reg     <= 1'b0;
            mul_p_reg     <= 1'b0;
            fin_div_reg   <= 1'b0;
            final_run_reg <= 1'b0;
            cnt_reg       <= '0;
            tgt_p_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load)          out_valid_reg <= 1'b1;
            else if (values.ready) out_valid_reg <= 1'b0;
            case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty) begin
                        mul_m_reg     <= q_data.has_digit;
                        add_m_reg     <= q_data.has_digit;
                        mul_p_reg     <= q_data.has_digit && q_data.is_frac;
                        fin_div_reg   <= q_data.fin;
                        final_run_reg <= 1'b0;
                        cnt_reg       <= q_data.exp_cnt;
                    end
                end
                B_DISPATCH:
                begin
                    case (job)
                        J_MUL_M:
                        begin
                            mul_m_reg <= 1'b0;
                            tgt_p_reg <= 1'b0;
                        end
                        J_ADD_M:   add_m_reg <= 1'b0;
                        J_MUL_P:
                        begin
                            mul_p_reg <= 1'b0;
                            tgt_p_reg <= 1'b1;
                        end
                        J_EXP_MUL:
                        begin
                            cnt_reg   <= cnt_reg - 11'd1;
                            tgt_p_reg <= 1'b1;
                        end
                        J_EXP_DIV: cnt_reg <= cnt_reg - 11'd1;
                        J_FINAL:
                        begin
                            fin_div_reg   <= 1'b0;
                            final_run_reg <= 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                B_ADD:      tgt_p_reg <= 1'b0;
                B_ROUND:
                begin
                    if (tgt_p_reg) p_reg <= rounded;
                    else           m_reg <= rounded;
                end
                B_DIV_WAIT: if (div_done && !final_run_reg) p_reg <= div_q;
                B_OUT:
                begin
                    if (out_load) begin
                        m_reg <= DBL_ZERO;
                        p_reg <= DBL_ONE;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE && !q_empty) begin
            ent_reg <= q_data;
        end
        if (state_reg == B_MUL) begin
            pre_sp_reg   <= mul_sp;
            pre_bits_reg <= mul_bits;
            pre_e_reg    <= mul_e;
            pre_s_reg    <= mul_s;
            pre_st_reg   <= mul_st;
        end else if (state_reg == B_ADD) begin
            pre_sp_reg   <= add_sp;
            pre_bits_reg <= add_bits;
            pre_e_reg    <= add_e;
            pre_s_reg    <= add_s;
            pre_st_reg   <= add_st;
        end
        if (out_load) begin
            out_bits_reg <= div_q;
        end
    end

endmodule

>>> hw/rtl/decimal_text_to_double.sv
// Top level of the decimal text to binary64 converter.
// Depends on dtd_pkg, dtd_in_if, dtd_out_if, dtd_front, dtd_fifo and dtd_back.
//
//   Channel   Direction  Carries                           Transfer happens when
//   chars     in         text_char[7:0], end_of_text       chars.valid && chars.ready
//   values    out        value_bits[63:0] (IEEE binary64)  values.valid && values.ready
//
// The parser takes one character per cycle while the four-entry queue has room.
// Each integer digit passes through the sequencer's shared multiply-by-ten, add and rounding
// steps, and a fraction digit also through a multiply-by-ten and rounding of the divisor.
// The last character adds, per exponent step, a multiply by ten for a negative exponent or
// a division by ten for a positive one, plus the final division (bit-serial divider).
// Reset is asynchronous and active low; it clears the parser, queue and sequencer.
// A waiting result stalls the sequencer only once the next final division has finished.
module decimal_text_to_double
    import dtd_pkg::*;
#(
    parameter int EXPONENT_LIMIT = 1023
)
(
    input  logic      clk,
    input  logic      rst_n,
    dtd_in_if.sink    chars,
    dtd_out_if.source values
);

    logic       q_push, q_pop, q_full, q_empty;
    q_entry_t   q_wdata, q_rdata;
    back_stat_t bk_stat;

    // The front end classifies each character and records what arithmetic it needs.
    dtd_front #(
        .EXPONENT_LIMIT (EXPONENT_LIMIT)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_wdata)
    );

    // The queue decouples the one-character-per-cycle parser from the slower arithmetic.
    dtd_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    // The back end carries out the rounded double operations in the required order.
    dtd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_rdata),
        .q_pop   (q_pop),
        .values  (values),
        .stat    (bk_stat)
    );

    // The parser must never write into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue written while full");

    // The sequencer must never take an entry from an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue read while empty");

    // A new result is only presented after the sequencer's delivery step.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(values.valid) |-> $past(bk_stat.delivering))
        else $error("result appeared without delivery");

    // Delivery is only ever entered from the final division.
    a_delivery_order: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(bk_stat.delivering) |-> $past(bk_stat.final_div))
        else $error("delivery without final division");

endmodule

>>> tb/decimal_text_to_double_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for decimal_text_to_double: strings go in one character per transfer.
// Depends on dtd_pkg, dtd_in_if, dtd_out_if and the decimal_text_to_double top level.
module decimal_text_to_double_test;
    import dtd_pkg::*;

    logic clk;
    logic rst_n;

    dtd_in_if  chars_if ();
    dtd_out_if values_if ();

    decimal_text_to_double u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_if.sink),
        .values (values_if.source)
    );

    // Clock with a 12 ns period.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // One pending character transfer: the code and the end-of-string mark.
    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } char_item_t;

    char_item_t  pending_chars[$];
    logic [63:0] expected_values[$];
    int          error_count = 0;
    int          char_count  = 0;

    // Idle rates in percent, changed by the stimulus process between phases.
    int sender_idle_pct   = 23;
    int receiver_idle_pct = 67;

    // Long receiver hold-off: the stimulus process raises the request count and the
    // receiver process serves it by counting the stretch out itself.
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    // Running state of the conversion, mirroring what the block keeps between characters.
    parse_phase_t conv_phase;
    logic         conv_negative;
    real          conv_mantissa;
    real          conv_divisor;
    logic         conv_exp_negative;
    int unsigned  conv_exp_count;

    function automatic void clear_conversion();
        conv_phase        = PH_WS;
        conv_negative     = 1'b0;
        conv_mantissa     = 0.0;
        conv_divisor      = 1.0;
        conv_exp_negative = 1'b0;
        conv_exp_count    = 0;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // Mantissa times ten, then plus the digit: two separately rounded operations.
    function automatic void append_digit(input logic [7:0] c);
        real scaled;
        scaled        = 10.0 * conv_mantissa;
        conv_mantissa = scaled + real'(int'(c - CH_ZERO));
    endfunction

    // Advances the parse by one character. Each phase that does not take the
    // character hands it on to the next phase, so the tests run in order.
    function automatic void take_character(input logic [7:0] c);
        int unsigned grown;
        if (conv_phase > PH_EXP)
        begin
            conv_phase = PH_DONE;
            return;
        end
        if (conv_phase == PH_WS)
        begin
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                return;
            conv_phase = PH_SIGN;
        end
        if (conv_phase == PH_SIGN)
        begin
            conv_phase = PH_INT;
            if (c == CH_MINUS || c == CH_PLUS)
            begin
                conv_negative = (c == CH_MINUS);
                return;
            end
        end
        if (conv_phase == PH_INT)
        begin
            if (is_digit(c))
            begin
                append_digit(c);
                return;
            end
            conv_phase = PH_DOT;
        end
        if (conv_phase == PH_DOT)
        begin
            conv_phase = PH_FRAC;
            if (c == CH_DOT)
                return;
        end
        if (conv_phase == PH_FRAC)
        begin
            if (is_digit(c))
            begin
                append_digit(c);
                conv_divisor = conv_divisor * 10.0;
                return;
            end
            conv_phase = PH_E;
        end
        if (conv_phase == PH_E)
        begin
            conv_phase = PH_ESIGN;
            if (c == CH_E)
                return;
        end
        if (conv_phase == PH_ESIGN)
        begin
            conv_phase = PH_EXP;
            if (c == CH_MINUS || c == CH_PLUS)
            begin
                conv_exp_negative = (c == CH_MINUS);
                return;
            end
        end
        if (is_digit(c))
        begin
            grown          = conv_exp_count * 10 + int'(c - CH_ZERO);
            conv_exp_count = (grown > 1023) ? 1023 : grown;
            return;
        end
        conv_phase = PH_DONE;
    endfunction

    // Applies the exponent to the divisor step by step, then divides.
    // Any NaN comes out as the canonical quiet NaN.
    function automatic logic [63:0] finish_conversion();
        real         divisor;
        real         signed_mantissa;
        logic [63:0] bits;
        divisor = conv_divisor;
        for (int unsigned i = 0; i < conv_exp_count; i++)
        begin
            if (conv_exp_negative)
                divisor = divisor * 10.0;
            else
                divisor = divisor / 10.0;
        end
        signed_mantissa = (conv_negative ? -1.0 : 1.0) * conv_mantissa;
        bits = $realtobits(signed_mantissa / divisor);
        if (bits[62:52] == EXP_ONES && bits[51:0] != 52'd0)
            bits = DBL_QNAN;
        return bits;
    endfunction

    // Driver: offers queued characters, holds an offer until it is taken, and
    // predicts the converted value whenever a string-ending transfer happens.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_if.valid       <= 1'b0;
            chars_if.text_char   <= 8'd0;
            chars_if.end_of_text <= 1'b0;
            clear_conversion();
        end
        else
        begin
            if (chars_if.valid && chars_if.ready)
            begin
                take_character(chars_if.text_char);
                if (chars_if.end_of_text)
                begin
                    expected_values.push_back(finish_conversion());
                    clear_conversion();
                end
            end
            if (!chars_if.valid || chars_if.ready)
            begin
                if (pending_chars.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    char_item_t next_char;
                    next_char = pending_chars.pop_front();
                    chars_if.valid       <= 1'b1;
                    chars_if.text_char   <= next_char.code;
                    chars_if.end_of_text <= next_char.last;
                end
                else
                begin
                    chars_if.valid <= 1'b0;
                end
            end
        end
    end

    // Receiver and monitor: random ready, the long hold-off, and the comparison
    // of every value transfer with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            values_if.ready <= 1'b0;
            hold_left       <= 0;
        end
        else
        begin
            if (values_if.valid && values_if.ready)
            begin
                if (expected_values.size() == 0)
                begin
                    $error("value_bits: unexpected transfer, actual %h", values_if.value_bits);
                    error_count++;
                end
                else
                begin
                    logic [63:0] predicted;
                    predicted = expected_values.pop_front();
                    if (values_if.value_bits !== predicted)
                    begin
                        $error("value_bits: expected %h, actual %h",
                               predicted, values_if.value_bits);
                        error_count++;
                    end
                end
            end
            if (hold_served != hold_requests)
            begin
                hold_served++;
                hold_left       <= 600;
                values_if.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left       <= hold_left - 1;
                values_if.ready <= 1'b0;
            end
            else
            begin
                values_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    task automatic queue_char(input logic [7:0] code, input logic last);
        char_item_t item;
        item.code = code;
        item.last = last;
        pending_chars.push_back(item);
        char_count++;
    endtask

    task automatic queue_text(input string text);
        for (int i = 0; i < text.len(); i++)
            queue_char(text[i], i == text.len() - 1);
    endtask

    // A number in the accepted grammar with random content, now and then with
    // stray trailing characters. Exponents stay small except in rare cases,
    // because every positive exponent step costs the block a full division.
    task automatic queue_number();
        string text;
        int    count;
        text = "";
        count = $urandom_range(2);
        repeat (count)
        begin
            int pick;
            pick = $urandom_range(5);
            text = {text, string'((pick == 5) ? CH_SPACE : CH_TAB + 8'(pick))};
        end
        case ($urandom_range(2))
            0: text = {text, "-"};
            1: text = {text, "+"};
            default: ;
        endcase
        count = $urandom_range(6);
        repeat (count)
            text = {text, string'(CH_ZERO + 8'($urandom_range(9)))};
        if ($urandom_range(3) != 0)
        begin
            text = {text, "."};
            count = $urandom_range(5);
            repeat (count)
                text = {text, string'(CH_ZERO + 8'($urandom_range(9)))};
        end
        if ($urandom_range(2) != 0)
        begin
            if ($urandom_range(5) != 0)
                text = {text, "e"};
            case ($urandom_range(2))
                0: text = {text, "-"};
                1: text = {text, "+"};
                default: ;
            endcase
            if ($urandom_range(60) == 0)
                text = {text, $sformatf("%0d", $urandom_range(999))};
            else
                text = {text, $sformatf("%0d", $urandom_range(30))};
        end
        if ($urandom_range(4) == 0)
            text = {text, string'(8'($urandom_range(255)))};
        if (text.len() == 0)
            text = "0";
        queue_text(text);
    endtask

    // Arbitrary bytes, including codes 0 and 128 to 255.
    task automatic queue_noise();
        int count;
        count = $urandom_range(1, 5);
        for (int i = 0; i < count; i++)
            queue_char(8'($urandom_range(255)), i == count - 1);
    endtask

    task automatic queue_random(input int chars_wanted);
        int goal;
        goal = char_count + chars_wanted;
        while (char_count < goal)
        begin
            if ($urandom_range(99) < 15)
                queue_noise();
            else
                queue_number();
        end
    endtask

    // Waits until every queued character is taken and every value has arrived.
    task automatic wait_drained();
        while (pending_chars.size() > 0 || chars_if.valid || expected_values.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        string digits;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed strings: extremes, the exponent sign without an 'e', stray
        // characters, high codes, saturation, zero over zero and inf over inf.
        queue_text("0");
        queue_text("-");
        queue_char(8'd0, 1'b1);
        queue_char(8'd255, 1'b1);
        queue_text({" \t", string'(8'd10), string'(8'd11), string'(8'd12), "\r+123.456e-7"});
        queue_text("-1.5e3");
        queue_text("12-3");
        queue_text("7+2");
        queue_text("1.5x99");
        queue_text({"42", string'(8'd128), "9"});
        queue_text("-.5");
        queue_text("0.e1");
        queue_text("9999999999999999999999");
        queue_text("1e999");
        queue_text("1e-999");
        queue_text("0e999");
        queue_text("4.9e-324");
        queue_text("1.7976931348623157e308");
        queue_text("e5");
        queue_text("--1");
        digits = "";
        repeat (320)
            digits = {digits, "9"};
        queue_text({digits, "e-400"});
        wait_drained();

        // Random part in three idling phases; the sender pauses for a full
        // drain between them, and the last phase opens with a long hold-off.
        queue_random(150);
        wait_drained();
        sender_idle_pct   = 67;
        receiver_idle_pct = 23;
        queue_random(150);
        wait_drained();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_requests++;
        queue_random(150);
        wait_drained();
        repeat (200) @(posedge clk);

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #60_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
